>>> sv/assert_macros.svh
// assert_macros.svh: assertion shorthand for the compacting array store checks.
// Needs nothing else; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/cas_pkg.sv
// cas_pkg: shared types and codes for the compacting array store.
// Used by the controller, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

    // default number of entries in the store
    localparam int DEPTH_DEFAULT = 256;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // source of the result word
    typedef enum logic [1:0] {
        RS_ZERO,
        RS_ONES,
        RS_MEM
    } t_rsel;

    // controller -> datapath commands
    typedef struct packed {
        logic       capture;    // latch the incoming item
        logic       app_wr;     // write the new value at the list end
        logic       cnt_inc;
        logic       cnt_dec;
        logic       rd_at_idx;  // read the entry at the index
        logic       rd_next;    // read index+1, advance the shift index
        logic       shift_wr;   // write last read word one place down
        logic       respond;    // load the result registers
        t_rsel      rsel;
        logic [1:0] status;
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] op;
        logic       is_full;
        logic       in_range;
        logic       rd_last;    // index+1 is at or past the list end
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/cas_controller.sv
// cas_controller: sequencing state machine of the compacting array store.
// Depends on cas_pkg for command/status types and operation codes.
`timescale 1ns / 1ps
`default_nettype none

module cas_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire cas_pkg::t_dp_stat  i_stat,
    output logic                    o_busy,
    output logic                    o_valid,
    output cas_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_GET_WAIT,
        S_SHIFT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op)
                    cas_pkg::OP_APPEND: begin
                        o_cmd.respond = 1'b1;
                        o_cmd.rsel    = cas_pkg::RS_ZERO;
                        if (i_stat.is_full) begin
                            o_cmd.status = cas_pkg::ST_FULL;
                        end else begin
                            o_cmd.status  = cas_pkg::ST_OK;
                            o_cmd.app_wr  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    cas_pkg::OP_REMOVE: begin
                        if (!i_stat.in_range) begin
                            o_cmd.respond = 1'b1;
                            o_cmd.rsel    = cas_pkg::RS_ZERO;
                            o_cmd.status  = cas_pkg::ST_RANGE;
                            n_valid       = 1'b1;
                            n_state       = S_IDLE;
                        end else if (i_stat.rd_last) begin
                            // removing the last entry needs no move
                            o_cmd.cnt_dec = 1'b1;
                            o_cmd.respond = 1'b1;
                            o_cmd.rsel    = cas_pkg::RS_ZERO;
                            o_cmd.status  = cas_pkg::ST_OK;
                            n_valid       = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            // fetch the first entry behind the gap
                            o_cmd.rd_next = 1'b1;
                            n_state       = S_SHIFT;
                        end
                    end
                    cas_pkg::OP_GET: begin
                        if (i_stat.in_range) begin
                            o_cmd.rd_at_idx = 1'b1;
                            n_state         = S_GET_WAIT;
                        end else begin
                            o_cmd.respond = 1'b1;
                            o_cmd.rsel    = cas_pkg::RS_ONES;
                            o_cmd.status  = cas_pkg::ST_RANGE;
                            n_valid       = 1'b1;
                            n_state       = S_IDLE;
                        end
                    end
                    default: begin
                        // unused opcode: no change, plain ok
                        o_cmd.respond = 1'b1;
                        o_cmd.rsel    = cas_pkg::RS_ZERO;
                        o_cmd.status  = cas_pkg::ST_OK;
                        n_valid       = 1'b1;
                        n_state       = S_IDLE;
                    end
                endcase
            end
            S_GET_WAIT: begin
                o_cmd.respond = 1'b1;
                o_cmd.rsel    = cas_pkg::RS_MEM;
                o_cmd.status  = cas_pkg::ST_OK;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            S_SHIFT: begin
                // write the fetched word one place down
                o_cmd.shift_wr = 1'b1;
                if (i_stat.rd_last) begin
                    // that was the final entry behind the gap
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.respond = 1'b1;
                    o_cmd.rsel    = cas_pkg::RS_ZERO;
                    o_cmd.status  = cas_pkg::ST_OK;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> sv/cas_datapath.sv
// cas_datapath: entry store, element count, shift index and result registers.
// Depends on cas_pkg; driven by cas_controller commands.
`timescale 1ns / 1ps
`default_nettype none

module cas_datapath #(
    parameter int DEPTH = cas_pkg::DEPTH_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cas_pkg::t_dp_cmd   i_cmd,
    output cas_pkg::t_dp_stat       o_stat,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [7:0]  i_position,
    input  wire logic signed [31:0] i_new_value,
    output logic signed      [31:0] o_read_value,
    output logic             [1:0]  o_status,
    output logic             [8:0]  o_entry_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    // entry store, registered read port
    logic [31:0]        r_mem [DEPTH];
    logic [31:0]        r_rdata;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [IW-1:0]      r_wr_addr;
    logic [1:0]         r_op;
    logic [7:0]         r_pos;
    logic [31:0]        r_value;
    logic signed [31:0] r_read_value;
    logic [1:0]         r_status;

    logic [XW-1:0]      w_pos_ext;
    logic [XW-1:0]      w_cnt_ext;
    logic [CW:0]        w_idx_p1;
    logic [IW-1:0]      w_rd_addr;
    logic               w_rd_en;
    logic               w_wr_en;
    logic [IW-1:0]      w_wr_addr;
    logic [31:0]        w_wr_data;
    logic [CW+8:0]      w_cnt_out;

    // index arithmetic and compares
    assign w_pos_ext = XW'(r_pos);
    assign w_cnt_ext = XW'(r_count);
    assign w_idx_p1  = {1'b0, r_idx} + (CW+1)'(1);

    assign o_stat.op       = r_op;
    assign o_stat.is_full  = (r_count >= CW'(DEPTH));
    assign o_stat.in_range = (w_pos_ext < w_cnt_ext);
    assign o_stat.rd_last  = (w_idx_p1 >= {1'b0, r_count});

    // memory port muxing
    assign w_rd_en   = i_cmd.rd_at_idx | i_cmd.rd_next;
    assign w_rd_addr = i_cmd.rd_next ? w_idx_p1[IW-1:0] : r_idx[IW-1:0];
    assign w_wr_en   = i_cmd.app_wr | i_cmd.shift_wr;
    assign w_wr_addr = i_cmd.app_wr ? r_count[IW-1:0] : r_wr_addr;
    assign w_wr_data = i_cmd.app_wr ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    // item capture and shift index
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_pos   <= i_position;
            r_value <= i_new_value;
            r_idx   <= CW'(i_position);
        end else if (i_cmd.rd_next) begin
            r_wr_addr <= r_idx[IW-1:0];
            r_idx     <= w_idx_p1[CW-1:0];
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_status <= i_cmd.status;
            case (i_cmd.rsel)
                cas_pkg::RS_ONES: r_read_value <= '1;
                cas_pkg::RS_MEM:  r_read_value <= r_rdata;
                default:          r_read_value <= '0;
            endcase
        end
    end

    assign w_cnt_out     = {9'd0, r_count};
    assign o_entry_count = w_cnt_out[8:0];
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;

endmodule

`default_nettype wire

>>> sv/compacting_array_store.sv
// Compacting array store: a dense list of signed 32-bit words in a store of DEPTH
// entries. start is taken while busy is low; each item gives exactly one result,
// shown for one cycle with o_valid, which the receiver must take then (no stall).
// Remove at position p moves the entries behind p down one place; the store has
// one read and one write port, so they move down one per cycle. o_entry_count is
// the count after the item.
// Depends on cas_pkg, cas_controller and cas_datapath.
`timescale 1ns / 1ps
`default_nettype none

module compacting_array_store #(
    parameter int DEPTH = cas_pkg::DEPTH_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [7:0]  i_position,
    input  wire logic signed [31:0] i_new_value,
    output logic                    o_valid,
    output logic signed      [31:0] o_read_value,
    output logic             [1:0]  o_status,
    output logic             [8:0]  o_entry_count
);

    cas_pkg::t_dp_cmd  w_cmd;
    cas_pkg::t_dp_stat w_stat;
    logic              w_busy;

    // item accepted only while idle
    cas_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start & ~w_busy),
        .i_stat  (w_stat),
        .o_busy  (w_busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    cas_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    assign busy = w_busy;

endmodule

`default_nettype wire

>>> sv/cas_checker.sv
// cas_checker: port-level checks of the compacting array store, bound to the top.
// Depends on cas_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cas_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire logic signed [31:0] o_read_value,
    input wire logic        [1:0]  o_status
);

    logic w_range_res;
    logic w_word_ok;

    // range-error results and the words they may carry
    assign w_range_res = o_valid && (o_status == cas_pkg::ST_RANGE);
    assign w_word_ok   = (o_read_value == 32'sd0) || (o_read_value == -32'sd1);

    // a result only appears once the block is free again
    `CAS_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)

    // an accepted item occupies the block next cycle
    `CAS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)

    // status is always a defined code
    `CAS_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_valid, o_status <= cas_pkg::ST_FULL)

    // a range error returns zero or the all-ones word
    `CAS_ASSERT_SAME(a_range_word, i_clk, i_rst_n, w_range_res, w_word_ok)

endmodule

bind compacting_array_store cas_checker u_cas_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);

`default_nettype wire

>>> sim/cas_result_checker.sv
// cas_result_checker: watches the item and result channels of the compacting array store,
// predicts each result from its own copy of the list and compares field by field.
// Depends on cas_pkg for the operation and status codes.
`timescale 1ns / 1ps

module cas_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic        [1:0]  i_op,
    input  logic        [7:0]  i_position,
    input  logic signed [31:0] i_new_value,
    input  logic               i_valid,
    input  logic signed [31:0] i_read_value,
    input  logic        [1:0]  i_status,
    input  logic        [8:0]  i_entry_count,
    output int                 o_error_count,
    output int                 o_pending
);
    import cas_pkg::*;

    localparam int SLOTS = DEPTH_DEFAULT;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic        [1:0]  status;
        logic        [8:0]  entry_count;
    } t_outcome;

    // shadow copy of the list
    logic signed [31:0] list_words [SLOTS];
    logic        [8:0]  held_count = '0;

    t_outcome awaited [$];
    t_outcome want;
    t_outcome seen;
    int       mismatches  = 0;
    int       outstanding = 0;

    assign o_error_count = mismatches;
    assign o_pending     = outstanding;

    // apply one item to the shadow list and return the result it should give
    function automatic t_outcome apply_item(input logic [1:0] op, input logic [7:0] pos,
                                            input logic signed [31:0] word);
        t_outcome res;
        int       k;
        res = '{read_value: '0, status: ST_OK, entry_count: '0};
        case (op)
            OP_APPEND: begin
                if (held_count >= SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[held_count] = word;
                    held_count = held_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos >= held_count) begin
                    res.status = ST_RANGE;
                end else begin
                    // close the gap: later entries move down one place
                    for (k = pos; k + 1 < held_count; k++)
                        list_words[k] = list_words[k + 1];
                    held_count = held_count - 1'b1;
                end
            end
            OP_GET: begin
                if (pos >= held_count) begin
                    res.status     = ST_RANGE;
                    res.read_value = -32'sd1;
                end else begin
                    res.read_value = list_words[pos];
                end
            end
            default: ;  // unused code: no operation
        endcase
        res.entry_count = held_count;
        return res;
    endfunction

    // results are matched before new items are queued, so a result can never
    // pair with the item accepted at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                seen = '{read_value: i_read_value, status: i_status,
                         entry_count: i_entry_count};
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result: read_value %0d status %0d count %0d",
                             $time, seen.read_value, seen.status, seen.entry_count);
                    mismatches++;
                end else begin
                    want = awaited.pop_front();
                    if (seen.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, seen.read_value);
                        mismatches++;
                    end
                    if (seen.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, seen.status);
                        mismatches++;
                    end
                    if (seen.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, seen.entry_count);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy)
                awaited.push_back(apply_item(i_op, i_position, i_new_value));
            outstanding = awaited.size();
        end
    end

endmodule

>>> sim/testbench.sv
// testbench: drives directed and random list operations into the compacting array store
// and reports the verdict from the failure count of the result checker.
// Depends on cas_pkg, compacting_array_store and cas_result_checker.
`timescale 1ns / 1ps

module testbench;
    import cas_pkg::*;

    localparam logic [1:0] OP_NOP       = 2'd3;  // unused code, must act as no operation
    localparam int         ITEM_TARGET  = 850;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } t_burst_mode;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic        [1:0]  i_op        = OP_APPEND;
    logic        [7:0]  i_position  = '0;
    logic signed [31:0] i_new_value = '0;
    logic               busy;
    logic               o_valid;
    logic signed [31:0] o_read_value;
    logic        [1:0]  o_status;
    logic        [8:0]  o_entry_count;
    int                 error_count;
    int                 pending;

    // stimulus bookkeeping: list length as seen from the sender side
    int          list_len   = 0;
    int          items_sent = 0;
    bit          steady     = 1'b0;
    t_burst_mode mode;
    int          burst_len;
    int          roll;
    int          n;

    compacting_array_store #(
        .DEPTH(DEPTH_DEFAULT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_new_value  (i_new_value),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_entry_count(o_entry_count)
    );

    cas_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_new_value  (i_new_value),
        .i_valid      (o_valid),
        .i_read_value (o_read_value),
        .i_status     (o_status),
        .i_entry_count(o_entry_count),
        .o_error_count(error_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // present one item after a random gap and return at the edge that accepts it
    task automatic issue_op(input logic [1:0] op, input logic [7:0] pos,
                            input logic [31:0] word);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_op        <= op;
        i_position  <= pos;
        i_new_value <= word;
        do @(posedge i_clk); while (busy);
        items_sent++;
        case (op)
            OP_APPEND: if (list_len < DEPTH_DEFAULT) list_len++;
            OP_REMOVE: if (pos < list_len) list_len--;
            default: ;
        endcase
    endtask

    // index: mostly valid, favoring both ends, sometimes just past or anywhere
    function automatic logic [7:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (list_len == 0 || r < 8)
            return 8'($urandom_range(0, 255));
        if (r < 14 && list_len < DEPTH_DEFAULT)
            return 8'(list_len);
        if (r < 30)
            return 8'd0;
        if (r < 46)
            return 8'(list_len - 1);
        return 8'($urandom_range(0, list_len - 1));
    endfunction

    // word: mostly random, sometimes the extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, extreme words, bad indexes, shifts, unused code
        issue_op(OP_GET,    8'd0,   32'h0);
        issue_op(OP_REMOVE, 8'd0,   32'h0);
        issue_op(OP_APPEND, 8'd0,   32'h7fff_ffff);
        issue_op(OP_APPEND, 8'd0,   32'h8000_0000);
        issue_op(OP_APPEND, 8'd0,   32'h0000_0000);
        issue_op(OP_APPEND, 8'd0,   32'hffff_ffff);
        issue_op(OP_APPEND, 8'd255, 32'h1234_5678);
        for (n = 0; n < 5; n++)
            issue_op(OP_GET, 8'(n), 32'h0);
        issue_op(OP_GET,    8'd5,   32'h0);
        issue_op(OP_GET,    8'd255, 32'h0);
        issue_op(OP_REMOVE, 8'd255, 32'h0);
        issue_op(OP_REMOVE, 8'd1,   32'h0);
        issue_op(OP_GET,    8'd1,   32'h0);
        issue_op(OP_REMOVE, 8'd3,   32'h0);
        issue_op(OP_NOP,    8'd255, 32'hffff_ffff);
        issue_op(OP_REMOVE, 8'd0,   32'h0);
        issue_op(OP_GET,    8'd0,   32'h0);
        issue_op(OP_GET,    8'd1,   32'h0);

        // fill the store to the top with reads and removes mixed in
        n = 0;
        while (list_len < DEPTH_DEFAULT) begin
            if (n % 32 == 0)
                steady = ($urandom_range(0, 3) == 0);
            n++;
            roll = $urandom_range(0, 99);
            if (roll < 88)
                issue_op(OP_APPEND, 8'($urandom_range(0, 255)), pick_word());
            else if (roll < 95)
                issue_op(OP_GET, pick_position(), pick_word());
            else
                issue_op(OP_REMOVE, pick_position(), pick_word());
        end

        // refused appends on the full store
        steady = 1'b0;
        for (n = 0; n < 6; n++) begin
            issue_op(OP_APPEND, 8'($urandom_range(0, 255)), pick_word());
            issue_op(OP_GET, 8'd255, 32'h0);
        end

        // random bursts that push the list up, down or hold it level
        while (items_sent < ITEM_TARGET) begin
            mode      = t_burst_mode'($urandom_range(0, 2));
            burst_len = $urandom_range(20, 40);
            steady    = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_GROW:   roll = (roll < 65) ? 0 : (roll < 75) ? 1 : (roll < 95) ? 2 : 3;
                    MODE_SHRINK: roll = (roll < 10) ? 0 : (roll < 65) ? 1 : (roll < 95) ? 2 : 3;
                    default:     roll = (roll < 35) ? 0 : (roll < 60) ? 1 : (roll < 95) ? 2 : 3;
                endcase
                case (roll)
                    0:       issue_op(OP_APPEND, 8'($urandom_range(0, 255)), pick_word());
                    1:       issue_op(OP_REMOVE, pick_position(), pick_word());
                    2:       issue_op(OP_GET, pick_position(), pick_word());
                    default: issue_op(OP_NOP, 8'($urandom_range(0, 255)), pick_word());
                endcase
            end
        end
        start <= 1'b0;

        // drain: every result must arrive, then watch for stray ones
        while (pending != 0) @(posedge i_clk);
        repeat (DEPTH_DEFAULT + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
